>>> sv/tcch_pkg.sv
// Shared constants, types and the arctangent table of the compass heading block.
package tcch_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // Normaliser divider
    localparam int QB     = 17;     // quotient bits before clipping
    localparam int DIV_RW = 35;     // partial remainder width
    localparam int DIV_DW = 17;     // divisor width

    // Angle conversion: 2^32 = 36000 * BA_BASE + BA_FRAC
    localparam logic [31:0] BA_BASE    = 32'd119304;
    localparam logic [31:0] BA_FRAC    = 32'd23296;
    localparam logic [31:0] BA_HALF    = 32'd18000;
    localparam logic [31:0] CDEG_TURN  = 32'd36000;
    localparam logic [63:0] RECIP_M    = 64'd977343669;   // floor(2^45 / 36000)
    localparam int          RECIP_SH   = 45;

    // CORDIC
    localparam int ANG_W = 32;
    localparam int ROT_W = 34;
    localparam int VEC_W = 52;
    localparam logic signed [ROT_W-1:0] ROT_GAIN = 34'sd652032874;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        logic neg;
        logic ovf;
    } t_div_ctl;

    function automatic logic [ANG_W-1:0] atan_ang(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/tcch_in_if.sv
// Sample channel: raw magnetometer axes and attitude angles.
interface tcch_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic signed [15:0] roll_cdeg;
    logic signed [15:0] pitch_cdeg;

    modport source (output valid, raw_x, raw_y, raw_z, roll_cdeg, pitch_cdeg, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, roll_cdeg, pitch_cdeg, output ready);
endinterface

>>> sv/tcch_out_if.sv
// Result channel: normalised axes, heading and clip flag.
interface tcch_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [15:0] heading_cdeg;
    logic               saturated;

    modport source (output valid, norm_x, norm_y, norm_z, heading_cdeg, saturated, input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, heading_cdeg, saturated, output ready);
endinterface

>>> sv/tilt_compensated_compass_heading.sv
// Tilt-compensated compass heading: normaliser, sine/cosine and atan2 pipeline.
//
//  channel   dir  handshake            payload
//  i_smp     in   valid/ready          raw_x raw_y raw_z roll_cdeg pitch_cdeg
//  o_res     out  valid/ready          norm_x norm_y norm_z heading_cdeg saturated
//  i_cfg_*   in   write enable only    index 0..5, 16-bit data
//
//  One transaction per clock while the output is not stalled. The pipeline depth is set by
//  the 17-cell divider, the two CORDIC cell rows and the product stages between them.
//  A stalled output freezes the whole pipeline; i_smp.ready is low only then.
//  Reset clears the stage valid flags and the calibration registers.
module tilt_compensated_compass_heading #(
    parameter int CORDIC_STAGES = tcch_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcch_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [15:0]                       i_cfg_wdata,
    tcch_in_if.sink                           i_smp,
    tcch_out_if.source                        o_res
);
    import tcch_pkg::*;

    localparam int LN  = QB + 2;
    localparam int LA  = CORDIC_STAGES + 6;
    localparam int LJ  = (LN > LA) ? LN : LA;
    localparam int LAT = LJ + 5 + CORDIC_STAGES;

    // ---------------- control ----------------
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv       = !r_vld[LAT-1] || o_res.ready;
    assign i_smp.ready = w_adv;
    assign o_res.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_smp.valid};
        end
    end

    // ---------------- calibration registers ----------------
    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
            r_min_z <= '0;
            r_max_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_X: r_min_x <= i_cfg_wdata;
                CFG_MAX_X: r_max_x <= i_cfg_wdata;
                CFG_MIN_Y: r_min_y <= i_cfg_wdata;
                CFG_MAX_Y: r_max_y <= i_cfg_wdata;
                CFG_MIN_Z: r_min_z <= i_cfg_wdata;
                CFG_MAX_Z: r_max_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- normaliser ----------------
    logic signed [16:0] w_v  [3];
    logic signed [15:0] w_lo [3];
    logic signed [15:0] w_hi [3];
    logic signed [15:0] w_nq [3];
    logic               w_nsat [3];

    assign w_v[0]  = 17'(i_smp.raw_x);
    assign w_v[1]  = -17'(i_smp.raw_y);
    assign w_v[2]  = 17'(i_smp.raw_z);
    assign w_lo[0] = r_min_x;
    assign w_hi[0] = r_max_x;
    assign w_lo[1] = r_min_y;
    assign w_hi[1] = r_max_y;
    assign w_lo[2] = r_min_z;
    assign w_hi[2] = r_max_z;

    generate
        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic signed [18:0] w_e;
            logic signed [16:0] w_den;
            logic [15:0]        w_ud;
            logic [17:0]        w_s;
            logic [DIV_RW-1:0]  w_n;
            logic [DIV_DW-1:0]  w_d;
            t_div_ctl           w_ctl;
            logic [DIV_RW-1:0]  c_rem [QB+1];
            logic [DIV_DW-1:0]  c_den [QB+1];
            logic [QB-1:0]      c_quo [QB+1];
            t_div_ctl           c_ctl [QB+1];
            logic [QB-1:0]      w_mag;
            logic [17:0]        w_negmag;
            logic signed [15:0] r_q;
            logic               r_sat;

            assign w_e   = (19'(w_v[a]) <<< 1) - 19'(w_hi[a]) - 19'(w_lo[a]);
            assign w_den = 17'(w_hi[a]) - 17'(w_lo[a]);
            // zero range counts as a scale of one
            assign w_ud  = (w_den == 17'sd0) ? 16'd2
                         : 16'((w_den < 17'sd0) ? -w_den : w_den);
            assign w_s   = 18'((w_e < 19'sd0) ? -w_e : w_e);
            assign w_n   = (DIV_RW'(w_s) << 15) + DIV_RW'(w_ud);
            assign w_d   = DIV_DW'({w_ud, 1'b0});
            assign w_ctl.ovf = (w_n >= (DIV_RW'(w_d) << QB));
            assign w_ctl.neg = (w_e < 19'sd0) ^ (w_den < 17'sd0) ^ (a == 0);

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    c_rem[0] <= w_n;
                    c_den[0] <= w_d;
                    c_ctl[0] <= w_ctl;
                end
            end
            assign c_quo[0] = '0;

            for (genvar j = 0; j < QB; j++) begin : g_cell
                tcch_div_cell #(.K(QB - 1 - j)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_adv),
                    .i_rem (c_rem[j]),
                    .i_den (c_den[j]),
                    .i_quo (c_quo[j]),
                    .i_ctl (c_ctl[j]),
                    .o_rem (c_rem[j+1]),
                    .o_den (c_den[j+1]),
                    .o_quo (c_quo[j+1]),
                    .o_ctl (c_ctl[j+1])
                );
            end

            assign w_mag    = c_quo[QB];
            assign w_negmag = -{1'b0, w_mag};

            // sign and clip
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (c_ctl[QB].ovf) begin
                        r_sat <= 1'b1;
                        r_q   <= c_ctl[QB].neg ? 16'sh8000 : 16'sh7fff;
                    end else if (c_ctl[QB].neg) begin
                        r_sat <= (w_mag > QB'(32768));
                        r_q   <= (w_mag > QB'(32768)) ? 16'sh8000 : 16'(w_negmag);
                    end else begin
                        r_sat <= (w_mag > QB'(32767));
                        r_q   <= (w_mag > QB'(32767)) ? 16'sh7fff : 16'(w_mag);
                    end
                end
            end

            assign w_nq[a]   = r_q;
            assign w_nsat[a] = r_sat;
        end
    endgenerate

    // ---------------- sine and cosine of roll and pitch ----------------
    logic signed [31:0] w_sin [2];
    logic signed [31:0] w_cos [2];

    generate
        for (genvar g = 0; g < 2; g++) begin : g_ang
            logic signed [15:0]   w_cdeg;
            logic [15:0]          w_m;
            logic [29:0]          r_a0_t;
            logic [31:0]          r_a0_base;
            logic                 r_a0_neg;
            logic [29:0]          r_a1_t;
            logic [14:0]          r_a1_q0;
            logic [31:0]          r_a1_base;
            logic                 r_a1_neg;
            logic [16:0]          r_a2_rem;
            logic [14:0]          r_a2_q0;
            logic [31:0]          r_a2_base;
            logic                 r_a2_neg;
            logic [31:0]          w_a3;
            logic [ANG_W-1:0]     r_a3_ang;
            logic                 w_flip;
            logic [ANG_W-1:0]     w_turned;
            logic signed [ROT_W-1:0] c_x [CORDIC_STAGES+1];
            logic signed [ROT_W-1:0] c_y [CORDIC_STAGES+1];
            logic [ROT_W-1:0]     c_z [CORDIC_STAGES+1];
            logic                 c_f [CORDIC_STAGES+1];
            logic signed [ROT_W-1:0] w_ny;
            logic signed [ROT_W-1:0] w_nx;
            logic signed [31:0]   r_s;
            logic signed [31:0]   r_c;

            assign w_cdeg = (g == 0) ? i_smp.roll_cdeg : i_smp.pitch_cdeg;
            assign w_m    = 16'((w_cdeg < 16'sd0) ? -17'(w_cdeg) : 17'(w_cdeg));

            // binary angle = round(|cdeg| * 2^32 / 36000), split as base + fraction
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_a0_t    <= 30'(32'(w_m) * BA_FRAC + BA_HALF);
                    r_a0_base <= 32'(w_m) * BA_BASE;
                    r_a0_neg  <= (w_cdeg < 16'sd0);

                    r_a1_q0   <= 15'((64'(r_a0_t) * RECIP_M) >> RECIP_SH);
                    r_a1_t    <= r_a0_t;
                    r_a1_base <= r_a0_base;
                    r_a1_neg  <= r_a0_neg;

                    r_a2_rem  <= 17'(31'(r_a1_t) - 31'(r_a1_q0) * 31'(CDEG_TURN));
                    r_a2_q0   <= r_a1_q0;
                    r_a2_base <= r_a1_base;
                    r_a2_neg  <= r_a1_neg;

                    r_a3_ang  <= r_a2_neg ? (32'd0 - w_a3) : w_a3;
                end
            end

            assign w_a3 = r_a2_base + 32'(r_a2_q0) + 32'(r_a2_rem >= 17'(CDEG_TURN));

            // turn the back half-plane round so the CORDIC sees |z| <= quarter turn
            assign w_flip   = |((r_a3_ang + QUARTER_TURN) & HALF_TURN);
            assign w_turned = w_flip ? (r_a3_ang + HALF_TURN) : r_a3_ang;

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    c_x[0] <= ROT_GAIN;
                    c_y[0] <= '0;
                    c_z[0] <= ROT_W'(signed'(w_turned));
                    c_f[0] <= w_flip;
                end
            end

            for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cell
                tcch_cordic_cell #(
                    .W(ROT_W), .ZW(ROT_W), .IDX(j), .VEC(0), .TAG_W(1)
                ) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_adv),
                    .i_x   (c_x[j]),
                    .i_y   (c_y[j]),
                    .i_z   (c_z[j]),
                    .i_tag (c_f[j]),
                    .o_x   (c_x[j+1]),
                    .o_y   (c_y[j+1]),
                    .o_z   (c_z[j+1]),
                    .o_tag (c_f[j+1])
                );
            end

            assign w_ny = c_f[CORDIC_STAGES] ? -c_y[CORDIC_STAGES] : c_y[CORDIC_STAGES];
            assign w_nx = c_f[CORDIC_STAGES] ? -c_x[CORDIC_STAGES] : c_x[CORDIC_STAGES];

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_s <= 32'(w_ny);
                    r_c <= 32'(w_nx);
                end
            end

            assign w_sin[g] = r_s;
            assign w_cos[g] = r_c;
        end
    endgenerate

    // ---------------- alignment ----------------
    logic [48:0]  w_nrm_in, w_nrm_al;
    logic [127:0] w_trg_in, w_trg_al;

    assign w_nrm_in = {w_nq[0], w_nq[1], w_nq[2], w_nsat[0] | w_nsat[1] | w_nsat[2]};
    assign w_trg_in = {w_sin[0], w_cos[0], w_sin[1], w_cos[1]};

    tcch_dly #(.W(49), .DEPTH(LJ - LN)) u_dly_nrm (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_nrm_in),
        .o_q   (w_nrm_al)
    );

    tcch_dly #(.W(128), .DEPTH(LJ - LA)) u_dly_trg (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_trg_in),
        .o_q   (w_trg_al)
    );

    // ---------------- tilt compensation ----------------
    logic signed [31:0] w_sr, w_cr, w_sp, w_cp;
    logic signed [31:0] r_p1_srsp, r_p1_srcp, r_p1_cr, r_p1_cp, r_p1_sp;
    logic [48:0]        r_p1_nrm;
    logic signed [15:0] w_nx, w_ny, w_nz;
    logic signed [47:0] r_p2_xc, r_p2_zs, r_p2_xss, r_p2_yc, r_p2_zsc;
    logic signed [VEC_W-1:0] r_p3_xh, r_p3_yh;

    assign w_sr = w_trg_al[127:96];
    assign w_cr = w_trg_al[95:64];
    assign w_sp = w_trg_al[63:32];
    assign w_cp = w_trg_al[31:0];
    assign w_nx = r_p1_nrm[48:33];
    assign w_ny = r_p1_nrm[32:17];
    assign w_nz = r_p1_nrm[16:1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_srsp <= 32'((64'(w_sr) * 64'(w_sp)) >>> 30);
            r_p1_srcp <= 32'((64'(w_sr) * 64'(w_cp)) >>> 30);
            r_p1_cr   <= w_cr;
            r_p1_cp   <= w_cp;
            r_p1_sp   <= w_sp;
            r_p1_nrm  <= w_nrm_al;

            r_p2_xc   <= 48'(w_nx) * 48'(r_p1_cp);
            r_p2_zs   <= 48'(w_nz) * 48'(r_p1_sp);
            r_p2_xss  <= 48'(w_nx) * 48'(r_p1_srsp);
            r_p2_yc   <= 48'(w_ny) * 48'(r_p1_cr);
            r_p2_zsc  <= 48'(w_nz) * 48'(r_p1_srcp);

            r_p3_xh   <= VEC_W'(r_p2_xc) + VEC_W'(r_p2_zs);
            r_p3_yh   <= VEC_W'(r_p2_xss) + VEC_W'(r_p2_yc) - VEC_W'(r_p2_zsc);
        end
    end

    // ---------------- atan2 ----------------
    logic signed [VEC_W-1:0] v_x [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] v_y [CORDIC_STAGES+1];
    logic [ANG_W-1:0]        v_z [CORDIC_STAGES+1];
    logic                    v_nul [CORDIC_STAGES+1];
    logic                    w_left;

    assign w_left = (r_p3_xh < 0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            v_x[0]   <= w_left ? -r_p3_xh : r_p3_xh;
            v_y[0]   <= w_left ? -r_p3_yh : r_p3_yh;
            v_z[0]   <= w_left ? HALF_TURN : '0;
            v_nul[0] <= (r_p3_xh == 0) && (r_p3_yh == 0);
        end
    end

    generate
        for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_vec
            tcch_cordic_cell #(
                .W(VEC_W), .ZW(ANG_W), .IDX(j), .VEC(1), .TAG_W(1)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_x   (v_x[j]),
                .i_y   (v_y[j]),
                .i_z   (v_z[j]),
                .i_tag (v_nul[j]),
                .o_x   (v_x[j+1]),
                .o_y   (v_y[j+1]),
                .o_z   (v_z[j+1]),
                .o_tag (v_nul[j+1])
            );
        end
    endgenerate

    // x magnitude of the vectoring row is not needed beyond the cells
    logic [48:0] w_nrm_out;

    tcch_dly #(.W(49), .DEPTH(CORDIC_STAGES + 3)) u_dly_out (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r_p1_nrm),
        .o_q   (w_nrm_out)
    );

    // ---------------- heading and output register ----------------
    logic [48:0]        w_hprod;
    logic [16:0]        w_head;
    logic signed [15:0] r_o_nx, r_o_ny, r_o_nz;
    logic [15:0]        r_o_head;
    logic               r_o_sat;

    assign w_hprod = 49'(v_z[CORDIC_STAGES]) * 49'(CDEG_TURN) + (49'(1) << 31);
    assign w_head  = 17'(w_hprod >> 32);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_nx   <= w_nrm_out[48:33];
            r_o_ny   <= w_nrm_out[32:17];
            r_o_nz   <= w_nrm_out[16:1];
            r_o_sat  <= w_nrm_out[0];
            // null vector and a full turn both read as north
            r_o_head <= (v_nul[CORDIC_STAGES] || w_head >= 17'(CDEG_TURN))
                      ? 16'd0 : 16'(w_head);
        end
    end

    assign o_res.norm_x       = r_o_nx;
    assign o_res.norm_y       = r_o_ny;
    assign o_res.norm_z       = r_o_nz;
    assign o_res.heading_cdeg = r_o_head;
    assign o_res.saturated    = r_o_sat;

endmodule

>>> sv/tcch_div_cell.sv
// One restoring division cell: resolves a single quotient bit per clock while enabled.
module tcch_div_cell #(
    parameter int K = 0
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tcch_pkg::DIV_RW-1:0]    i_rem,
    input  logic [tcch_pkg::DIV_DW-1:0]    i_den,
    input  logic [tcch_pkg::QB-1:0]        i_quo,
    input  tcch_pkg::t_div_ctl             i_ctl,
    output logic [tcch_pkg::DIV_RW-1:0]    o_rem,
    output logic [tcch_pkg::DIV_DW-1:0]    o_den,
    output logic [tcch_pkg::QB-1:0]        o_quo,
    output tcch_pkg::t_div_ctl             o_ctl
);
    import tcch_pkg::*;

    logic [DIV_RW-1:0] w_sub;
    logic              w_take;
    logic [DIV_RW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [QB-1:0]     r_quo;
    t_div_ctl          r_ctl;

    assign w_sub  = DIV_RW'(i_den) << K;
    assign w_take = (i_rem >= w_sub);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_take ? (i_rem - w_sub) : i_rem;
            r_quo <= i_quo | (QB'(w_take) << K);
            r_den <= i_den;
            r_ctl <= i_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ctl = r_ctl;

endmodule

>>> sv/tcch_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
module tcch_cordic_cell #(
    parameter int W     = 34,
    parameter int ZW    = 34,
    parameter int IDX   = 0,
    parameter int VEC   = 0,
    parameter int TAG_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic [ZW-1:0]        i_z,
    input  logic [TAG_W-1:0]     i_tag,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic [ZW-1:0]        o_z,
    output logic [TAG_W-1:0]     o_tag
);
    import tcch_pkg::*;

    logic              w_pos;
    logic [ZW-1:0]     w_ang;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [ZW-1:0]     r_z;
    logic [TAG_W-1:0]  r_tag;

    // vectoring drives y towards zero, rotation drives z towards zero
    assign w_pos = (VEC != 0) ? i_y[W-1] : !i_z[ZW-1];
    assign w_ang = ZW'(atan_ang(IDX));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_pos) begin
                r_x <= i_x - (i_y >>> IDX);
                r_y <= i_y + (i_x >>> IDX);
                r_z <= i_z - w_ang;
            end else begin
                r_x <= i_x + (i_y >>> IDX);
                r_y <= i_y - (i_x >>> IDX);
                r_z <= i_z + w_ang;
            end
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;

endmodule

>>> sv/tcch_dly.sv
// Enabled shift line that keeps side data in step with the pipeline.
module tcch_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_line [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_line[0] <= i_d;
                    for (int i = 1; i < DEPTH; i++) begin
                        r_line[i] <= r_line[i-1];
                    end
                end
            end
            assign o_q = r_line[DEPTH-1];
        end
    endgenerate

endmodule

>>> sv/tcch_chk.sv
// Port-level checks on the result channel, bound to the top level.
module tcch_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [15:0] i_norm_x,
    input logic [15:0] i_norm_y,
    input logic [15:0] i_norm_z,
    input logic [15:0] i_heading,
    input logic        i_sat
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_heading) && $stable(i_norm_x))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_heading < 16'd36000)
        else $error("heading out of range");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sat |-> (i_norm_x == 16'h7fff || i_norm_x == 16'h8000 ||
                              i_norm_y == 16'h7fff || i_norm_y == 16'h8000 ||
                              i_norm_z == 16'h7fff || i_norm_z == 16'h8000))
        else $error("clip flag without a clipped axis");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind tilt_compensated_compass_heading tcch_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_norm_x  (o_res.norm_x),
    .i_norm_y  (o_res.norm_y),
    .i_norm_z  (o_res.norm_z),
    .i_heading (o_res.heading_cdeg),
    .i_sat     (o_res.saturated)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the tilt-compensated compass heading block.
typedef struct {
    logic signed [15:0] x, y, z, roll, pitch;
} sample_t;

typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic        [15:0] heading;
    logic               sat;
} result_t;

class heading_scoreboard;
    localparam int STAGES = 16;
    localparam longint GAIN = 652032874;
    localparam logic [31:0] HALF = 32'h8000_0000;
    localparam logic [31:0] QUARTER = 32'h4000_0000;

    longint arctan_steps[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    longint cal[6];
    result_t pending_results[$];
    int errors;

    function void set_calibration(int idx, logic signed [15:0] v);
        if (idx < 6) cal[idx] = v;
    endfunction

    function longint scale_axis(longint v, longint lo, longint hi, bit neg, ref bit sat);
        longint num, den, un, ud, mag, q;
        num = (2 * v - hi - lo) * 16384;
        den = hi - lo;
        if (den == 0) den = 2;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        mag = (2 * un + ud) / (2 * ud);
        q = ((num < 0) != (den < 0)) ? -mag : mag;
        if (neg) q = -q;
        if (q > 32767) begin q = 32767; sat = 1; end
        if (q < -32768) begin q = -32768; sat = 1; end
        return q;
    endfunction

    function logic [31:0] cdeg_to_turn(longint cdeg);
        longint unsigned m;
        logic [31:0] a;
        m = cdeg < 0 ? -cdeg : cdeg;
        a = 32'((m * 64'h1_0000_0000 + 18000) / 36000);
        if (cdeg < 0) a = -a;
        return a;
    endfunction

    function void rotate(logic [31:0] a, output longint s, output longint c);
        bit flip;
        longint x, y, z, nx;
        flip = ((a + QUARTER) & HALF) != 0;
        if (flip) a = a + HALF;
        x = GAIN;
        y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_steps[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_steps[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] z;
        longint nx;
        z = 0;
        if (x < 0) begin x = -x; y = -y; z = HALF; end
        for (int i = 0; i < STAGES; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - 32'(arctan_steps[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + 32'(arctan_steps[i]);
            end
            x = nx;
        end
        return z;
    endfunction

    function void note_sample(sample_t s);
        result_t r;
        bit sat;
        longint nx, ny, nz, sr, cr, sp, cp, xh, yh, hd;
        longint unsigned za;
        sat = 0;
        nx = scale_axis(longint'(s.x), cal[0], cal[1], 1, sat);
        ny = scale_axis(-longint'(s.y), cal[2], cal[3], 0, sat);
        nz = scale_axis(longint'(s.z), cal[4], cal[5], 0, sat);
        rotate(cdeg_to_turn(longint'(s.roll)), sr, cr);
        rotate(cdeg_to_turn(longint'(s.pitch)), sp, cp);
        xh = nx * cp + nz * sp;
        yh = nx * ((sr * sp) >>> 30) + ny * cr - nz * ((sr * cp) >>> 30);
        hd = 0;
        if (xh != 0 || yh != 0) begin
            za = vector_angle(yh, xh);
            hd = longint'((za * 36000 + 64'h8000_0000) >> 32);
            if (hd >= 36000) hd = 0;
        end
        r.nx = 16'(nx);
        r.ny = 16'(ny);
        r.nz = 16'(nz);
        r.heading = 16'(hd);
        r.sat = sat;
        pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d hdg=%0d sat=%0b", $time,
                     got.nx, got.ny, got.nz, got.heading, got.sat);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.nx !== exp_r.nx) begin
            $display("%0t: norm_x expected %0d actual %0d", $time, exp_r.nx, got.nx);
            errors++;
        end
        if (got.ny !== exp_r.ny) begin
            $display("%0t: norm_y expected %0d actual %0d", $time, exp_r.ny, got.ny);
            errors++;
        end
        if (got.nz !== exp_r.nz) begin
            $display("%0t: norm_z expected %0d actual %0d", $time, exp_r.nz, got.nz);
            errors++;
        end
        if (got.heading !== exp_r.heading) begin
            $display("%0t: heading expected %0d actual %0d", $time, exp_r.heading,
                     got.heading);
            errors++;
        end
        if (got.sat !== exp_r.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, exp_r.sat, got.sat);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import tcch_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    tcch_in_if  smp_if();
    tcch_out_if res_if();

    heading_scoreboard sb = new();
    bit calm_stretch;
    bit hold_request;
    int items_sent;

    always #1 i_clk = ~i_clk;

    tilt_compensated_compass_heading u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    initial begin
        smp_if.valid = 0;
        smp_if.raw_x = 0;
        smp_if.raw_y = 0;
        smp_if.raw_z = 0;
        smp_if.roll_cdeg = 0;
        smp_if.pitch_cdeg = 0;
        res_if.ready = 0;
    end

    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic signed [15:0] v);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.set_calibration(int'(idx), v);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic load_calibration(logic signed [15:0] x0, x1, y0, y1, z0, z1);
        // hold until the pipeline has drained
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        write_cal(CFG_MIN_X, x0);
        write_cal(CFG_MAX_X, x1);
        write_cal(CFG_MIN_Y, y0);
        write_cal(CFG_MAX_Y, y1);
        write_cal(CFG_MIN_Z, z0);
        write_cal(CFG_MAX_Z, z1);
        write_cal(3'd6, 16'h7fff);
        write_cal(3'd7, 16'h8000);
    endtask

    task automatic send_sample(sample_t s);
        if (!calm_stretch && $urandom_range(99) < 14) begin
            smp_if.valid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        smp_if.raw_x = s.x;
        smp_if.raw_y = s.y;
        smp_if.raw_z = s.z;
        smp_if.roll_cdeg = s.roll;
        smp_if.pitch_cdeg = s.pitch;
        smp_if.valid = 1;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(s);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_axis(longint lo, longint hi);
        longint a, b;
        a = lo < hi ? lo : hi;
        b = lo < hi ? hi : lo;
        if ($urandom_range(3) == 0) return 16'($urandom);
        a = a - 64 < -32768 ? -32768 : a - 64;
        b = b + 64 > 32767 ? 32767 : b + 64;
        return 16'(a + longint'($urandom_range(0, int'(b - a))));
    endfunction

    task automatic send_random(int n);
        sample_t s;
        for (int k = 0; k < n; k++) begin
            s.x = pick_axis(sb.cal[0], sb.cal[1]);
            s.y = -pick_axis(sb.cal[2], sb.cal[3]);
            s.z = pick_axis(sb.cal[4], sb.cal[5]);
            s.roll = 16'($urandom_range(0, 36000) - 18000);
            s.pitch = 16'($urandom_range(0, 36000) - 18000);
            if (items_sent == 650) hold_request = 1;
            send_sample(s);
        end
        smp_if.valid = 0;
    endtask

    task automatic send_directed();
        sample_t s;
        logic signed [15:0] ends[4] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
        logic signed [15:0] angs[6] = '{-16'sd18000, 16'sd18000, 16'sd0, 16'sd9000,
                                        -16'sd9000, 16'sd4500};
        for (int k = 0; k < 24; k++) begin
            s.x = ends[k % 4];
            s.y = ends[(k / 4) % 4];
            s.z = ends[(k + 2) % 4];
            s.roll = angs[k % 6];
            s.pitch = angs[(k / 6 + k) % 6];
            // null horizontal vector
            if (k == 0) begin
                s.x = 0; s.y = 0; s.z = 0;
            end
            send_sample(s);
        end
        smp_if.valid = 0;
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                res_if.ready = 0;
            end else begin
                res_if.ready = calm_stretch || ($urandom_range(99) >= 14);
            end
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                result_t r;
                r.nx = res_if.norm_x;
                r.ny = res_if.norm_y;
                r.nz = res_if.norm_z;
                r.heading = res_if.heading_cdeg;
                r.sat = res_if.saturated;
                sb.check_result(r);
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // reset calibration: zero range on every axis
        send_directed();
        load_calibration(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                         -16'sd32768, 16'sd32767);
        send_directed();
        load_calibration(16'sd32767, -16'sd32768, 16'sd500, -16'sd500, 16'sd100, 16'sd100);
        send_random(200);
        load_calibration(-16'sd300, 16'sd420, -16'sd250, 16'sd380, -16'sd600, 16'sd100);
        calm_stretch = 1;
        send_random(200);
        calm_stretch = 0;
        send_random(150);
        load_calibration(-16'sd2, 16'sd2, 16'sd7, 16'sd9, -16'sd1, 16'sd0);
        send_random(200);
        for (int p = 0; p < 3; p++) begin
            load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
            send_random(130);
        end
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
